@@ rtl/pressure_sensor_compensation_unit_macros.svh @@
// Assertion macros for the pressure sensor compensation unit.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef PRESSURE_SENSOR_COMPENSATION_UNIT_MACROS_SVH
`define PRESSURE_SENSOR_COMPENSATION_UNIT_MACROS_SVH

`define PSC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("psc: implication check failed");

`define PSC_ASSERT_DLY(lbl, ante, n, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ## n (cons)) \
    else $error("psc: delayed check failed");

`endif

@@ rtl/psc_pkg.sv @@
// Shared constants, register codes and helpers of the compensation unit.
// No dependencies.
package psc_pkg;

  localparam int unsigned DataW   = 64;
  localparam int unsigned RegW    = 48;
  localparam int unsigned CoefW   = 16;
  localparam int unsigned AddrW   = 5;

  localparam logic [DataW-1:0] TfineOffset = 64'd128000;
  localparam logic [DataW-1:0] PressBase   = 64'd1048576;
  localparam logic [DataW-1:0] PressScale  = 64'd3125;

  typedef enum logic [1:0] {
    RegTemp   = 2'd0,
    RegPressA = 2'd1,
    RegPressB = 2'd2,
    RegPressC = 2'd3
  } reg_idx_e;

  function automatic logic [DataW-1:0] sext16(input logic [CoefW-1:0] c);
    sext16 = {{(DataW-CoefW){c[CoefW-1]}}, c};
  endfunction

endpackage

@@ rtl/psc_mul64.sv @@
// Two-stage multiplier giving the low 64 bits of each lane's product.
// Built from 32x32 partial products; depends on psc_pkg.
module psc_mul64 #(
  parameter int unsigned Lanes = 1,
  parameter int unsigned SideW = 1
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    valid_i,
  input  logic [Lanes-1:0][psc_pkg::DataW-1:0]    a_i,
  input  logic [Lanes-1:0][psc_pkg::DataW-1:0]    b_i,
  input  logic [SideW-1:0]                        side_i,
  output logic                                    valid_o,
  output logic [Lanes-1:0][psc_pkg::DataW-1:0]    prod_o,
  output logic [SideW-1:0]                        side_o
);

  localparam int unsigned HalfW = psc_pkg::DataW / 2;

  logic [Lanes-1:0][psc_pkg::DataW-1:0] pp0_q;
  logic [Lanes-1:0][HalfW-1:0]          pp1_q;
  logic [Lanes-1:0][HalfW-1:0]          pp2_q;
  logic [SideW-1:0]                     side_q;
  logic                                 valid_q;
  logic [Lanes-1:0][psc_pkg::DataW-1:0] prod_q;
  logic [SideW-1:0]                     side2_q;
  logic                                 valid2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      valid2_q <= 1'b0;
    end else begin
      valid_q  <= valid_i;
      valid2_q <= valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Lanes; i++) begin
      pp0_q[i]  <= psc_pkg::DataW'(a_i[i][HalfW-1:0]) * psc_pkg::DataW'(b_i[i][HalfW-1:0]);
      pp1_q[i]  <= HalfW'(a_i[i][HalfW-1:0] * b_i[i][psc_pkg::DataW-1:HalfW]);
      pp2_q[i]  <= HalfW'(a_i[i][psc_pkg::DataW-1:HalfW] * b_i[i][HalfW-1:0]);
      prod_q[i] <= pp0_q[i] + {HalfW'(pp1_q[i] + pp2_q[i]), {HalfW{1'b0}}};
    end
    side_q  <= side_i;
    side2_q <= side_q;
  end

  assign valid_o = valid2_q;
  assign prod_o  = prod_q;
  assign side_o  = side2_q;

endmodule

@@ rtl/psc_div.sv @@
// Pipelined signed 64-bit divider, one quotient bit per stage, truncating.
// Depends on psc_pkg.
module psc_div #(
  parameter int unsigned SideW = 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  logic [psc_pkg::DataW-1:0] num_i,
  input  logic [psc_pkg::DataW-1:0] den_i,
  input  logic [SideW-1:0]          side_i,
  output logic                      valid_o,
  output logic [psc_pkg::DataW-1:0] quo_o,
  output logic [SideW-1:0]          side_o
);

  localparam int unsigned W = psc_pkg::DataW;

  logic [W-1:0]     rem_q  [W+1];
  logic [W-1:0]     dq_q   [W+1];
  logic [W-1:0]     dv_q   [W+1];
  logic             neg_q  [W+1];
  logic [SideW-1:0] side_q [W+1];
  logic [W:0]       vld_q;
  logic [W-1:0]     quo_q;
  logic [SideW-1:0] oside_q;
  logic             ovld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      ovld_q <= 1'b0;
    end else begin
      vld_q  <= {vld_q[W-1:0], valid_i};
      ovld_q <= vld_q[W];
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= '0;
    dq_q[0]   <= num_i[W-1] ? W'(-num_i) : num_i;
    dv_q[0]   <= den_i[W-1] ? W'(-den_i) : den_i;
    neg_q[0]  <= num_i[W-1] ^ den_i[W-1];
    side_q[0] <= side_i;
  end

  for (genvar k = 0; k < W; k++) begin : g_stage
    logic [W:0] trial;
    logic [W:0] diff;
    logic       ge;

    always_comb begin
      trial = {rem_q[k], dq_q[k][W-1]};
      diff  = trial - {1'b0, dv_q[k]};
      ge    = !diff[W];
    end

    always_ff @(posedge clk_i) begin
      rem_q[k+1]  <= ge ? diff[W-1:0] : trial[W-1:0];
      dq_q[k+1]   <= {dq_q[k][W-2:0], ge};
      dv_q[k+1]   <= dv_q[k];
      neg_q[k+1]  <= neg_q[k];
      side_q[k+1] <= side_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q   <= neg_q[W] ? W'(-dq_q[W]) : dq_q[W];
    oside_q <= side_q[W];
  end

  assign valid_o = ovld_q;
  assign quo_o   = quo_q;
  assign side_o  = oside_q;

endmodule

@@ rtl/pressure_sensor_compensation_unit.sv @@
// Top level of the pressure sensor compensation unit: registers, temperature
// stages, pressure multiply chain and divider. Depends on psc_pkg, psc_mul64,
// psc_div and pressure_sensor_compensation_unit_macros.svh.
//
//   channel   direction  signals
//   command   in/out     start, busy, raw_pressure_i, raw_temperature_i
//   result    out        result_valid_o, temperature_centi_o, pressure_q24_8_o,
//                        pressure_invalid_o
//   config    in/out     psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// One reading pair is taken every cycle; busy stays low.
// Each result passes the temperature stages, the multiply chain, the
// bit-per-stage divider, the second-order correction and the output register.
// Reset clears the valid bits and the coefficient registers; no clearing pass.
// The result strobe lasts one cycle and is never held off.
`include "pressure_sensor_compensation_unit_macros.svh"

module pressure_sensor_compensation_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [19:0]                raw_pressure_i,
  input  logic [19:0]                raw_temperature_i,
  output logic                       result_valid_o,
  output logic [31:0]                temperature_centi_o,
  output logic [31:0]                pressure_q24_8_o,
  output logic                       pressure_invalid_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [psc_pkg::AddrW-1:0]  paddr,
  input  logic [psc_pkg::DataW-1:0]  pwdata,
  output logic [psc_pkg::DataW-1:0]  prdata,
  output logic                       pready
);

  localparam int unsigned W       = psc_pkg::DataW;
  localparam int unsigned Latency = 18 + W + 2;

  // configuration
  logic [psc_pkg::RegW-1:0] tcoef_q, pcoa_q, pcob_q, pcoc_q;
  psc_pkg::reg_idx_e        widx;

  assign widx   = psc_pkg::reg_idx_e'(paddr[psc_pkg::AddrW-1:3]);
  assign pready = 1'b1;
  assign busy   = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tcoef_q <= '0;
      pcoa_q  <= '0;
      pcob_q  <= '0;
      pcoc_q  <= '0;
    end else if (psel && penable && pwrite) begin
      case (widx)
        psc_pkg::RegTemp:   tcoef_q <= pwdata[psc_pkg::RegW-1:0];
        psc_pkg::RegPressA: pcoa_q  <= pwdata[psc_pkg::RegW-1:0];
        psc_pkg::RegPressB: pcob_q  <= pwdata[psc_pkg::RegW-1:0];
        psc_pkg::RegPressC: pcoc_q  <= pwdata[psc_pkg::RegW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (widx)
      psc_pkg::RegTemp:   prdata = W'(tcoef_q);
      psc_pkg::RegPressA: prdata = W'(pcoa_q);
      psc_pkg::RegPressB: prdata = W'(pcob_q);
      psc_pkg::RegPressC: prdata = W'(pcoc_q);
      default:            prdata = '0;
    endcase
  end

  logic [15:0]        t1;
  logic signed [15:0] t2, t3;
  logic [W-1:0]       p1, p2, p3, p4, p5, p6, p7, p8, p9;

  assign t1 = tcoef_q[15:0];
  assign t2 = signed'(tcoef_q[31:16]);
  assign t3 = signed'(tcoef_q[47:32]);
  assign p1 = W'(pcoa_q[15:0]);
  assign p2 = psc_pkg::sext16(pcoa_q[31:16]);
  assign p3 = psc_pkg::sext16(pcoa_q[47:32]);
  assign p4 = psc_pkg::sext16(pcob_q[15:0]);
  assign p5 = psc_pkg::sext16(pcob_q[31:16]);
  assign p6 = psc_pkg::sext16(pcob_q[47:32]);
  assign p7 = psc_pkg::sext16(pcoc_q[15:0]);
  assign p8 = psc_pkg::sext16(pcoc_q[31:16]);
  assign p9 = psc_pkg::sext16(pcoc_q[47:32]);

  // temperature stages
  logic signed [17:0] s1_a_q;
  logic signed [16:0] s1_d_q;
  logic [19:0]        s1_adcp_q, s2_adcp_q, s3_adcp_q, s4_adcp_q, s5_adcp_q;
  logic signed [31:0] s2_x1t_q, s2_dd_q, s3_x1t_q, s3_x2t_q, s4_tfine_q, s5_temp_q;
  logic [W-1:0]       s5_x1p_q;
  logic [5:1]         sv_q;

  logic signed [33:0] at_full, dd_full;
  logic signed [31:0] at_w, x2a;
  logic signed [47:0] x2t_full;
  logic signed [31:0] x2t_w, t5;

  always_comb begin
    at_full  = s1_a_q * t2;
    at_w     = at_full[31:0];
    dd_full  = s1_d_q * s1_d_q;
    x2a      = s2_dd_q >>> 12;
    x2t_full = x2a * t3;
    x2t_w    = x2t_full[31:0];
    t5       = s4_tfine_q * 32'sd5 + 32'sd128;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q <= '0;
    end else begin
      sv_q <= {sv_q[4:1], start && !busy};
    end
  end

  always_ff @(posedge clk_i) begin
    s1_a_q     <= signed'({1'b0, raw_temperature_i[19:3]} - {1'b0, t1, 1'b0});
    s1_d_q     <= signed'({1'b0, raw_temperature_i[19:4]} - {1'b0, t1});
    s1_adcp_q  <= raw_pressure_i;
    s2_x1t_q   <= at_w >>> 11;
    s2_dd_q    <= dd_full[31:0];
    s2_adcp_q  <= s1_adcp_q;
    s3_x1t_q   <= s2_x1t_q;
    s3_x2t_q   <= x2t_w >>> 14;
    s3_adcp_q  <= s2_adcp_q;
    s4_tfine_q <= s3_x1t_q + s3_x2t_q;
    s4_adcp_q  <= s3_adcp_q;
    s5_temp_q  <= t5 >>> 8;
    s5_x1p_q   <= {{32{s4_tfine_q[31]}}, s4_tfine_q} - psc_pkg::TfineOffset;
    s5_adcp_q  <= s4_adcp_q;
  end

  // square and first coefficient products
  localparam int unsigned Side1W = 32 + 20;
  logic               m1_v;
  logic [2:0][W-1:0]  m1_p;
  logic [Side1W-1:0]  m1_s;

  psc_mul64 #(.Lanes(3), .SideW(Side1W)) u_mul1 (
    .clk_i, .rst_ni,
    .valid_i (sv_q[5]),
    .a_i     ({s5_x1p_q, s5_x1p_q, s5_x1p_q}),
    .b_i     ({p2, p5, s5_x1p_q}),
    .side_i  ({s5_temp_q, s5_adcp_q}),
    .valid_o (m1_v),
    .prod_o  (m1_p),
    .side_o  (m1_s)
  );

  localparam int unsigned Side2W = Side1W + 2 * W;
  logic               m2_v;
  logic [1:0][W-1:0]  m2_p;
  logic [Side2W-1:0]  m2_s;

  psc_mul64 #(.Lanes(2), .SideW(Side2W)) u_mul2 (
    .clk_i, .rst_ni,
    .valid_i (m1_v),
    .a_i     ({m1_p[0], m1_p[0]}),
    .b_i     ({p3, p6}),
    .side_i  ({m1_s, m1_p[1], m1_p[2]}),
    .valid_o (m2_v),
    .prod_o  (m2_p),
    .side_o  (m2_s)
  );

  // combine terms into the divisor base and the numerator base
  logic [W-1:0]  m2_xp5, m2_xp2, sqp3_sh, pb;
  logic [31:0]   m2_temp;
  logic [19:0]   m2_adcp;
  logic          s6_v_q;
  logic [W-1:0]  s6_x1b_q, s6_pn_q;
  logic [31:0]   s6_temp_q;

  assign m2_xp2  = m2_s[W-1:0];
  assign m2_xp5  = m2_s[2*W-1:W];
  assign m2_adcp = m2_s[2*W+19:2*W];
  assign m2_temp = m2_s[Side2W-1:2*W+20];
  assign sqp3_sh = W'($signed(m2_p[1]) >>> 8);
  assign pb      = psc_pkg::PressBase - W'(m2_adcp);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_v_q <= 1'b0;
    end else begin
      s6_v_q <= m2_v;
    end
  end

  always_ff @(posedge clk_i) begin
    s6_x1b_q  <= sqp3_sh + (m2_xp2 << 12) + (W'(1) << 47);
    s6_pn_q   <= (pb << 31) - m2_p[0] - (m2_xp5 << 17) - (p4 << 35);
    s6_temp_q <= m2_temp;
  end

  logic              m3_v;
  logic [1:0][W-1:0] m3_p;
  logic [31:0]       m3_s;

  psc_mul64 #(.Lanes(2), .SideW(32)) u_mul3 (
    .clk_i, .rst_ni,
    .valid_i (s6_v_q),
    .a_i     ({s6_pn_q, s6_x1b_q}),
    .b_i     ({psc_pkg::PressScale, p1}),
    .side_i  (s6_temp_q),
    .valid_o (m3_v),
    .prod_o  (m3_p),
    .side_o  (m3_s)
  );

  logic [W-1:0] den;
  logic         s7_v_q;
  logic [W-1:0] s7_num_q, s7_den_q;
  logic [32:0]  s7_side_q;

  assign den = W'($signed(m3_p[0]) >>> 33);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s7_v_q <= 1'b0;
    end else begin
      s7_v_q <= m3_v;
    end
  end

  always_ff @(posedge clk_i) begin
    s7_num_q  <= m3_p[1];
    s7_den_q  <= den;
    s7_side_q <= {m3_s, den == '0};
  end

  logic         dv_v;
  logic [W-1:0] dv_q;
  logic [32:0]  dv_s;

  psc_div #(.SideW(33)) u_div (
    .clk_i, .rst_ni,
    .valid_i (s7_v_q),
    .num_i   (s7_num_q),
    .den_i   (s7_den_q),
    .side_i  (s7_side_q),
    .valid_o (dv_v),
    .quo_o   (dv_q),
    .side_o  (dv_s)
  );

  // second-order pressure correction
  localparam int unsigned Side4W = 33 + W;
  logic [W-1:0]      q13;
  logic              m4_v;
  logic [1:0][W-1:0] m4_p;
  logic [Side4W-1:0] m4_s;

  assign q13 = W'($signed(dv_q) >>> 13);

  psc_mul64 #(.Lanes(2), .SideW(Side4W)) u_mul4 (
    .clk_i, .rst_ni,
    .valid_i (dv_v),
    .a_i     ({dv_q, p9}),
    .b_i     ({p8, q13}),
    .side_i  ({dv_s, dv_q}),
    .valid_o (m4_v),
    .prod_o  (m4_p),
    .side_o  (m4_s)
  );

  localparam int unsigned Side5W = Side4W + W;
  logic [W-1:0]      m4_q13;
  logic              m5_v;
  logic [0:0][W-1:0] m5_p;
  logic [Side5W-1:0] m5_s;

  assign m4_q13 = W'($signed(m4_s[W-1:0]) >>> 13);

  psc_mul64 #(.Lanes(1), .SideW(Side5W)) u_mul5 (
    .clk_i, .rst_ni,
    .valid_i (m4_v),
    .a_i     (m4_p[0]),
    .b_i     (m4_q13),
    .side_i  ({m4_s, m4_p[1]}),
    .valid_o (m5_v),
    .prod_o  (m5_p),
    .side_o  (m5_s)
  );

  logic [W-1:0] f_q, f_qp8, f_x1, f_x2, f_sum, f_sh, f_p;
  logic         f_zero;
  logic [31:0]  f_temp;
  logic         out_v_q;
  logic [31:0]  out_temp_q, out_press_q;
  logic         out_inv_q;

  always_comb begin
    f_qp8  = m5_s[W-1:0];
    f_q    = m5_s[2*W-1:W];
    f_zero = m5_s[2*W];
    f_temp = m5_s[2*W+32:2*W+1];
    f_x1   = W'($signed(m5_p[0]) >>> 25);
    f_x2   = W'($signed(f_qp8) >>> 19);
    f_sum  = f_q + f_x1 + f_x2;
    f_sh   = W'($signed(f_sum) >>> 8);
    f_p    = f_sh + (p7 << 4);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= m5_v;
    end
  end

  always_ff @(posedge clk_i) begin
    out_temp_q  <= f_temp;
    out_press_q <= f_zero ? '0 : f_p[31:0];
    out_inv_q   <= f_zero;
  end

  assign result_valid_o      = out_v_q;
  assign temperature_centi_o = out_temp_q;
  assign pressure_q24_8_o    = out_press_q;
  assign pressure_invalid_o  = out_inv_q;

  `PSC_ASSERT_DLY(a_result_latency, start && !busy, Latency, result_valid_o)
  `PSC_ASSERT_IMP(a_invalid_zero, result_valid_o && pressure_invalid_o, pressure_q24_8_o == '0)
  `PSC_ASSERT_IMP(a_prdata_upper, psel && !pwrite, prdata[W-1:psc_pkg::RegW] == '0)

endmodule
